### hw/rtl/aidpa_pkg.sv
`default_nettype none
package aidpa_pkg;

  // Sizes
  localparam int unsigned PoolDepth  = 1024;
  localparam int unsigned IdBits     = 10;
  localparam int unsigned PtrBits    = 11;
  localparam int unsigned RingSlots  = 64;
  localparam int unsigned SlotBits   = 6;
  localparam int unsigned MaxGrant   = 64;
  localparam int unsigned CntBits    = 16;
  localparam int unsigned TotBits    = 22;
  localparam int unsigned QuoBits    = 27;

  localparam logic [CntBits-1:0] SlotMax  = 16'hFFFF;
  localparam logic [TotBits-1:0] TotalMax = 22'h3FFFFF;
  localparam logic [10:0]        IdsMax   = 11'd2047;

  // Operation codes
  localparam logic [1:0] OpRequest = 2'd0;
  localparam logic [1:0] OpRelease = 2'd1;
  localparam logic [1:0] OpAdd     = 2'd2;
  localparam logic [1:0] OpTick    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] RegStatic = 3'd0;
  localparam logic [2:0] RegRate   = 3'd1;
  localparam logic [2:0] RegThresh = 3'd2;
  localparam logic [2:0] RegWindow = 3'd3;
  localparam logic [2:0] RegNodes  = 3'd4;

  // Divider handshake
  typedef struct packed {
    logic                 start;
    logic [37:0]          dividend;
    logic [32:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [QuoBits-1:0]   quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/adaptive_id_pool_allocator_unit.sv
`default_nettype none
// Channel   | Direction | Signals
// command   | in        | start_i, busy_o, operation_i, id_value_i, ask_count_i
// result    | out       | result_valid_o, granted_o, given_id_o, id_valid_o, last_o,
//           |           | pool_overflow_o
// config    | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// Release/add: slot read, then the result with the pool write. Tick: slot read,
// totals update, read of the slot entered, then clear and mode decision.
// Request: slot read, then the serial limit division; with IDs granted,
// one pool read per popped ID.
// Reset is asynchronous; the ring memories are swept to zero, all 64 slots,
// after reset with busy_o high. Config beats are taken only while idle.
// Results are strobed for one cycle each; the receiver cannot stall.
module adaptive_id_pool_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [9:0]  id_value_i,
  input  wire logic [6:0]  ask_count_i,
  output logic             result_valid_o,
  output logic [6:0]       granted_o,
  output logic [9:0]       given_id_o,
  output logic             id_valid_o,
  output logic             last_o,
  output logic             pool_overflow_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned SB = aidpa_pkg::SlotBits;
  localparam int unsigned CB = aidpa_pkg::CntBits;
  localparam int unsigned TB = aidpa_pkg::TotBits;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StRdA   = 4'd2;
  localparam logic [3:0] StExec  = 4'd3;
  localparam logic [3:0] StTickB = 4'd4;
  localparam logic [3:0] StTickC = 4'd5;
  localparam logic [3:0] StDivW  = 4'd6;
  localparam logic [3:0] StPop   = 4'd7;
  localparam logic [3:0] StPopO  = 4'd8;

  // configuration
  logic [15:0] sfac_q, rfac_q;
  logic [8:0]  thr_q;
  logic [5:0]  win_q;
  logic [10:0] nodes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sfac_q  <= 16'd256;
      rfac_q  <= 16'd256;
      thr_q   <= 9'd128;
      win_q   <= 6'd8;
      nodes_q <= 11'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        aidpa_pkg::RegStatic: sfac_q  <= cfg_data_i;
        aidpa_pkg::RegRate:   rfac_q  <= cfg_data_i;
        aidpa_pkg::RegThresh: thr_q   <= cfg_data_i[8:0];
        aidpa_pkg::RegWindow: win_q   <= cfg_data_i[5:0];
        aidpa_pkg::RegNodes:  nodes_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  logic [10:0] n_eff;
  logic [5:0]  w_eff;
  logic [8:0]  t_eff;
  assign n_eff = (nodes_q == 11'd0) ? 11'd1 : nodes_q;
  assign w_eff = (win_q == 6'd0) ? 6'd1 : (win_q == 6'd63 ? 6'd63 : win_q);
  assign t_eff = (thr_q > 9'd256) ? 9'd256 : thr_q;

  // state
  logic [3:0]  st_q, st_d;
  logic [10:0] pcnt_q, pcnt_d;
  logic [10:0] tids_q, tids_d;
  logic [TB-1:0] rqt_q, rqt_d, rlt_q, rlt_d;
  logic [SB-1:0] ptr_q, ptr_d;
  logic        wfull_q, wfull_d, smode_q, smode_d;
  logic [1:0]  op_q, op_d;
  logic [9:0]  id_q, id_d;
  logic [6:0]  ask_q, ask_d;
  logic [6:0]  g_q, g_d, k_q, k_d;
  logic [SB-1:0] nptr_q, nptr_d;
  logic        nfull_q, nfull_d;

  // memories
  logic [9:0]    pool_mem [aidpa_pkg::PoolDepth];
  logic [CB-1:0] rq_mem [aidpa_pkg::RingSlots];
  logic [CB-1:0] rl_mem [aidpa_pkg::RingSlots];
  logic          pw_en;  logic [9:0] pw_addr, pw_data, pr_addr, pr_data;
  logic          rw_en;  logic [SB-1:0] rw_addr, rr_addr;
  logic [CB-1:0] rqw_data, rlw_data, rq_rd, rl_rd;

  always_ff @(posedge clk_i) begin
    if (pw_en) pool_mem[pw_addr] <= pw_data;
    pr_data <= pool_mem[pr_addr];
  end
  always_ff @(posedge clk_i) begin
    if (rw_en) begin
      rq_mem[rw_addr] <= rqw_data;
      rl_mem[rw_addr] <= rlw_data;
    end
    rq_rd <= rq_mem[rr_addr];
    rl_rd <= rl_mem[rr_addr];
  end

  // limit divider
  aidpa_pkg::div_req_t dreq;
  aidpa_pkg::div_rsp_t drsp;
  aidpa_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [10:0] busy_ids;
  logic [37:0] prod;
  logic [32:0] den;
  logic [CB-1:0] rq_inc, rl_inc;
  logic [TB:0]   sum_rq, sum_rl;
  logic [TB-1:0] tq, tl;
  logic [19:0]   lhs;
  logic [20:0]   rhs;
  logic [10:0]   lim;
  logic [6:0]    gg;
  logic [SB:0]   pinc;

  assign busy_ids = (tids_q > n_eff) ? tids_q - n_eff : 11'd0;

  always_comb begin
    st_d = st_q; pcnt_d = pcnt_q; tids_d = tids_q; rqt_d = rqt_q; rlt_d = rlt_q;
    ptr_d = ptr_q; wfull_d = wfull_q; smode_d = smode_q;
    op_d = op_q; id_d = id_q; ask_d = ask_q; g_d = g_q; k_d = k_q;
    nptr_d = nptr_q; nfull_d = nfull_q;
    pw_en = 1'b0; pw_addr = pcnt_q[9:0]; pw_data = id_q;
    pr_addr = 10'(pcnt_q - 11'd1);
    rw_en = 1'b0; rw_addr = ptr_q; rr_addr = ptr_q;
    rqw_data = '0; rlw_data = '0;
    dreq = '0;
    result_valid_o = 1'b0; granted_o = '0; given_id_o = '0;
    id_valid_o = 1'b0; last_o = 1'b0; pool_overflow_o = 1'b0;
    rq_inc = (rq_rd == aidpa_pkg::SlotMax) ? rq_rd : rq_rd + 16'd1;
    rl_inc = (rl_rd == aidpa_pkg::SlotMax) ? rl_rd : rl_rd + 16'd1;
    sum_rq = {1'b0, rqt_q} + {7'd0, rq_rd};
    sum_rl = {1'b0, rlt_q} + {7'd0, rl_rd};
    tq = sum_rq[TB] ? aidpa_pkg::TotalMax : sum_rq[TB-1:0];
    tl = sum_rl[TB] ? aidpa_pkg::TotalMax : sum_rl[TB-1:0];
    pinc = {1'b0, ptr_q} + 7'd1;
    lhs = {pcnt_q, 8'd0} + 20'd0;
    rhs = {11'd0, 10'd256 - {1'b0, t_eff}} * {10'd0, busy_ids};
    prod = smode_q ? ({22'd0, sfac_q} * {27'd0, busy_ids})
                   : ({22'd0, rfac_q} * {16'd0, rlt_q});
    den  = smode_q ? {14'd0, n_eff, 8'd0} : {3'd0, rqt_q, 8'd0};
    lim = (|drsp.quotient[26:11] || drsp.quotient[10:0] > pcnt_q) ?
          pcnt_q : drsp.quotient[10:0];
    if (!smode_q && rqt_q == '0) lim = pcnt_q;
    if (smode_q && tids_q <= n_eff) lim = 11'd0;
    gg = (lim < {4'd0, ask_q}) ? lim[6:0] : ask_q;
    if (gg > 7'd64) gg = 7'd64;
    case (st_q)
      StClear: begin
        rw_en = 1'b1; rw_addr = ptr_q;
        ptr_d = ptr_q + 6'd1;
        if (ptr_q == 6'd63) st_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          op_d = operation_i; id_d = id_value_i; ask_d = ask_count_i;
          st_d = StRdA;
        end
      end
      StRdA: st_d = StExec;  // ring read of current slot lands
      StExec: begin
        case (op_q)
          aidpa_pkg::OpRequest: begin
            rw_en = 1'b1; rqw_data = rq_inc; rlw_data = rl_rd;
            dreq.start = 1'b1; dreq.dividend = prod; dreq.divisor = den;
            st_d = StDivW;
          end
          aidpa_pkg::OpRelease, aidpa_pkg::OpAdd: begin
            if (op_q == aidpa_pkg::OpRelease) begin
              rw_en = 1'b1; rqw_data = rq_rd; rlw_data = rl_inc;
            end
            result_valid_o = 1'b1; last_o = 1'b1;
            if (pcnt_q[10]) pool_overflow_o = 1'b1;
            else begin
              pw_en = 1'b1; pcnt_d = pcnt_q + 11'd1;
              if (op_q == aidpa_pkg::OpAdd && tids_q != aidpa_pkg::IdsMax)
                tids_d = tids_q + 11'd1;
            end
            st_d = StIdle;
          end
          default: begin
            rqt_d = tq; rlt_d = tl;
            nfull_d = wfull_q;
            if (pinc > {1'b0, w_eff}) begin
              nptr_d = '0; nfull_d = 1'b1;
            end else nptr_d = pinc[SB-1:0];
            st_d = StTickB;
          end
        endcase
      end
      StTickB: begin
        rr_addr = nptr_q;
        st_d = StTickC;
      end
      StTickC: begin
        if (nfull_q) begin
          rqt_d = (rqt_q > {6'd0, rq_rd}) ? rqt_q - {6'd0, rq_rd} : '0;
          rlt_d = (rlt_q > {6'd0, rl_rd}) ? rlt_q - {6'd0, rl_rd} : '0;
        end
        rw_en = 1'b1; rw_addr = nptr_q;
        ptr_d = nptr_q; wfull_d = nfull_q;
        smode_d = !nfull_q || ({1'b0, lhs} >= rhs);
        result_valid_o = 1'b1; last_o = 1'b1;
        st_d = StIdle;
      end
      StDivW: begin
        if (drsp.done) begin
          g_d = gg; k_d = '0;
          if (gg == 7'd0) begin
            result_valid_o = 1'b1; last_o = 1'b1;
            st_d = StIdle;
          end else st_d = StPop;
        end
      end
      StPop: begin
        // read address is pcnt-1; count drops as the read issues
        pcnt_d = pcnt_q - 11'd1;
        st_d = StPopO;
      end
      default: begin  // StPopO
        result_valid_o = 1'b1; granted_o = g_q; given_id_o = pr_data;
        id_valid_o = 1'b1;
        k_d = k_q + 7'd1;
        if (k_q + 7'd1 == g_q) begin
          last_o = 1'b1; st_d = StIdle;
        end else begin
          pcnt_d = pcnt_q - 11'd1;  // next read issued now at pcnt-1
        end
      end
    endcase
  end

  assign busy_o = (st_q != StIdle);
  // config only between items, never on the edge that takes a command
  assign cfg_ready_o = (st_q == StIdle) && !start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; pcnt_q <= '0; tids_q <= '0; rqt_q <= '0; rlt_q <= '0;
      ptr_q <= '0; wfull_q <= 1'b0; smode_q <= 1'b1;
      g_q <= '0; k_q <= '0; nptr_q <= '0; nfull_q <= 1'b0;
    end else begin
      st_q <= st_d; pcnt_q <= pcnt_d; tids_q <= tids_d; rqt_q <= rqt_d;
      rlt_q <= rlt_d; ptr_q <= ptr_d; wfull_q <= wfull_d; smode_q <= smode_d;
      g_q <= g_d; k_q <= k_d; nptr_q <= nptr_d; nfull_q <= nfull_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; id_q <= id_d; ask_q <= ask_d;
  end

  // checks
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= 11'd1024) else $error("pool count beyond depth");
  a_grant_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_valid_o |-> (granted_o != 7'd0 && granted_o <= 7'd64))
    else $error("grant out of range");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> st_q == StIdle)
    else $error("last beat did not end item");

endmodule
`default_nettype wire

### hw/rtl/aidpa_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The quotient saturates
// to QuoBits bits: any value that large already exceeds every limit.
module aidpa_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire aidpa_pkg::div_req_t req_i,
  output aidpa_pkg::div_rsp_t    rsp_o
);

  localparam int unsigned NBits = 38;

  logic [NBits-1:0] num_q, num_d;
  logic [32:0]      den_q, den_d;
  logic [NBits:0]   rem_q, rem_d;
  logic [NBits-1:0] quo_q, quo_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NBits:0]   shifted;

  // one bit of long division per cycle
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[NBits-1:0], num_q[NBits-1]};
    if (req_i.start) begin
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'(NBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NBits-2:0], 1'b0};
      if (shifted >= {6'd0, den_q}) begin
        rem_d = shifted - {6'd0, den_q};
        quo_d = {quo_q[NBits-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = (|quo_q[NBits-1:aidpa_pkg::QuoBits]) ?
                          '1 : quo_q[aidpa_pkg::QuoBits-1:0];

endmodule
`default_nettype wire
